>>> rtl/ktst_pkg.sv
`timescale 1ns / 1ps

package ktst_pkg;

    localparam int KEY_SPACE = 65536;
    localparam int KEY_BITS  = $clog2(KEY_SPACE);
    localparam int NODE_BITS = KEY_BITS + 1;
    localparam int CNT_BITS  = KEY_BITS + 1;
    localparam int KEY_W     = 16;
    localparam int RANK_W    = 17;

    typedef logic [NODE_BITS-1:0] node_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    typedef struct packed {
        logic              action;
        logic [KEY_W-1:0]  key_value;
        logic [RANK_W-1:0] rank;
    } in_word_t;

    typedef struct packed {
        logic [KEY_W-1:0] taken_key;
        logic             found;
    } out_word_t;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_TAKE   = 1'b1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLEAR,
        OP_WAIT,
        OP_RD_FIRST,
        OP_IN_CHK,
        OP_UP_INC,
        OP_TK_CHK,
        OP_DESC,
        OP_TK_LEAF,
        OP_UP_DEC,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_CLR_DONE,
        COND_ACCEPT,
        COND_TAKE,
        COND_SKIP,
        COND_ROOT,
        COND_MISS,
        COND_LEAF_NEXT,
        COND_OUT_FREE
    } cond_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_CLEAR   = 4'd0;
    localparam step_t ST_WAIT    = 4'd1;
    localparam step_t ST_FIRST   = 4'd2;
    localparam step_t ST_IN_CHK  = 4'd3;
    localparam step_t ST_IN_UP   = 4'd4;
    localparam step_t ST_TK_CHK  = 4'd5;
    localparam step_t ST_TK_DESC = 4'd6;
    localparam step_t ST_TK_LEAF = 4'd7;
    localparam step_t ST_TK_UP   = 4'd8;
    localparam step_t ST_EMIT    = 4'd9;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t tgt_true;
        step_t tgt_false;
    } ctrl_word_t;

    // microprogram: next step is tgt_true when the condition holds, else tgt_false
    function automatic ctrl_word_t rom_word(input step_t s);
        ctrl_word_t w;
        case (s)
            ST_CLEAR:   w = '{OP_CLEAR,    COND_CLR_DONE,  ST_WAIT,    ST_CLEAR};
            ST_WAIT:    w = '{OP_WAIT,     COND_ACCEPT,    ST_FIRST,   ST_WAIT};
            ST_FIRST:   w = '{OP_RD_FIRST, COND_TAKE,      ST_TK_CHK,  ST_IN_CHK};
            ST_IN_CHK:  w = '{OP_IN_CHK,   COND_SKIP,      ST_WAIT,    ST_IN_UP};
            ST_IN_UP:   w = '{OP_UP_INC,   COND_ROOT,      ST_WAIT,    ST_IN_UP};
            ST_TK_CHK:  w = '{OP_TK_CHK,   COND_MISS,      ST_EMIT,    ST_TK_DESC};
            ST_TK_DESC: w = '{OP_DESC,     COND_LEAF_NEXT, ST_TK_LEAF, ST_TK_DESC};
            ST_TK_LEAF: w = '{OP_TK_LEAF,  COND_ALWAYS,    ST_TK_UP,   ST_TK_UP};
            ST_TK_UP:   w = '{OP_UP_DEC,   COND_ROOT,      ST_EMIT,    ST_TK_UP};
            ST_EMIT:    w = '{OP_EMIT,     COND_OUT_FREE,  ST_WAIT,    ST_EMIT};
            default:    w = '{OP_NOP,      COND_ALWAYS,    ST_WAIT,    ST_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/ktst_ram.sv
`timescale 1ns / 1ps

module ktst_ram #(
    parameter int ADDR_BITS = 17,
    parameter int DATA_BITS = 17
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/kth_smallest_take_set.sv
`timescale 1ns / 1ps

// Order-statistic set of keys 0..KEY_SPACE-1 held as a tree of presence counts in one
// 2*KEY_SPACE-entry RAM (one write and one registered read a cycle), driven by a ten-step
// microprogram. After reset every RAM entry is swept to zero before the first word is
// taken. An insert sets an absent key's leaf and adds one to each count up to the root,
// or stops at the leaf if the key is present; a take walks down the tree and back up,
// clearing the leaf and taking one off each count, or goes straight to emit when the
// rank is out of range. Each level costs one RAM read, which sets the pace. The result
// sits in an output register, so the next word is taken while it waits.
module kth_smallest_take_set (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  ktst_pkg::in_word_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ktst_pkg::out_word_t  m_data
);

    import ktst_pkg::*;

    step_t      step_reg, step_next;
    node_t      clr_reg, clr_next;
    logic       m_valid_reg, m_valid_next;
    out_word_t  m_data_reg, m_data_next;
    in_word_t   item_reg, item_next;
    node_t      node_reg, node_next;
    cnt_t       want_reg, want_next;
    logic [KEY_W-1:0] taken_reg, taken_next;
    logic       found_reg, found_next;

    ctrl_word_t cw;
    logic       cond;
    logic       wr_en;
    node_t      wr_addr;
    cnt_t       wr_data;
    node_t      rd_addr;
    cnt_t       rd_data;

    node_t      leaf_addr;
    logic       in_range;
    logic       skip;
    logic       miss;
    logic       go_right;
    node_t      desc_node;
    logic       out_free;

    ktst_ram #(
        .ADDR_BITS (NODE_BITS),
        .DATA_BITS (CNT_BITS)
    ) u_tree (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign leaf_addr = NODE_BITS'(KEY_SPACE) | NODE_BITS'(item_reg.key_value);
    assign in_range  = 32'(item_reg.key_value) < KEY_SPACE;
    assign skip      = !in_range || (rd_data != '0);
    assign miss      = (item_reg.rank == '0) || (32'(item_reg.rank) > 32'(rd_data));
    // rd_data is the left child's count while descending
    assign go_right  = rd_data < want_reg;
    assign desc_node = {node_reg[NODE_BITS-2:0], go_right};
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        cw           = rom_word(step_reg);
        wr_en        = 1'b0;
        wr_addr      = node_reg;
        wr_data      = '0;
        rd_addr      = node_reg;
        node_next    = node_reg;
        want_next    = want_reg;
        item_next    = item_reg;
        taken_next   = taken_reg;
        found_next   = found_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;

        case (cw.op)
            OP_CLEAR: begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + NODE_BITS'(1);
            end
            OP_WAIT: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_data;
                end
            end
            OP_RD_FIRST: begin
                node_next = (item_reg.action == ACT_TAKE) ? NODE_BITS'(1) : leaf_addr;
                rd_addr   = node_next;
            end
            OP_IN_CHK: begin
                if (!skip) begin
                    wr_en   = 1'b1;
                    wr_data = CNT_BITS'(1);
                end
                node_next = node_reg >> 1;
                rd_addr   = node_next;
            end
            OP_UP_INC, OP_UP_DEC: begin
                wr_en     = 1'b1;
                wr_data   = (cw.op == OP_UP_INC) ? rd_data + CNT_BITS'(1)
                                                 : rd_data - CNT_BITS'(1);
                node_next = node_reg >> 1;
                rd_addr   = node_next;
            end
            OP_TK_CHK: begin
                want_next  = CNT_BITS'(item_reg.rank);
                found_next = !miss;
                taken_next = '0;
                rd_addr    = NODE_BITS'(2);
            end
            OP_DESC: begin
                if (go_right) begin
                    want_next = want_reg - rd_data;
                end
                node_next = desc_node;
                rd_addr   = {desc_node[NODE_BITS-2:0], 1'b0};
            end
            OP_TK_LEAF: begin
                wr_en      = 1'b1;
                taken_next = KEY_W'(node_reg[KEY_BITS-1:0]);
                node_next  = node_reg >> 1;
                rd_addr    = node_next;
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{taken_key: taken_reg, found: found_reg};
                end
            end
            default: begin
            end
        endcase

        case (cw.cond)
            COND_ALWAYS:    cond = 1'b1;
            COND_CLR_DONE:  cond = &clr_reg;
            COND_ACCEPT:    cond = s_valid;
            COND_TAKE:      cond = item_reg.action == ACT_TAKE;
            COND_SKIP:      cond = skip;
            COND_ROOT:      cond = node_reg == NODE_BITS'(1);
            COND_MISS:      cond = miss;
            COND_LEAF_NEXT: cond = desc_node[NODE_BITS-1];
            COND_OUT_FREE:  cond = out_free;
            default:        cond = 1'b1;
        endcase

        step_next = cond ? cw.tgt_true : cw.tgt_false;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg    <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            step_reg    <= step_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        item_reg   <= item_next;
        node_reg   <= node_next;
        want_reg   <= want_next;
        taken_reg  <= taken_next;
        found_reg  <= found_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a word still owed while descending means at least one key lies under this node
    a_want_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_TK_DESC) |-> (want_reg != '0))
        else $error("descent rank ran out");

    // every node on the path of a taken key holds that key, so counts cannot be zero
    a_dec_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_reg == ST_TK_UP) |-> (rd_data != '0))
        else $error("count underflow on take path");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && step_reg != ST_CLEAR) |-> (wr_addr != rd_addr))
        else $error("read and write to the same node");

    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(step_reg) == ST_EMIT))
        else $error("result raised outside emit step");

endmodule
